// ===== hdl/hetu8_pkg.sv =====
`timescale 1ns / 1ps
package hetu8_pkg;

    localparam int MAX_NAME_DEF = 8;
    localparam int KEY_CHARS    = 8;

    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_SEMI = 8'h3b;

    typedef struct packed {
        logic accept;
        logic emit_direct;
        logic emit_flush;
        logic emit_tail;
    } hetu8_cmd_t;

    typedef struct packed {
        logic job_flush;
        logic job_tail;
        logic tail_pend;
        logic job_single;
        logic flush_last;
        logic tail_last;
        logic out_free;
    } hetu8_stat_t;

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a) ||
               (c >= 8'h61 && c <= 8'h7a);
    endfunction

    // key holds the name right aligned, first char in the highest used byte
    function automatic logic [16:0] ent_lookup(input logic [63:0] key);
        logic        hit;
        logic [15:0] cp;
        hit = 1'b1;
        cp  = 16'h0000;
        case (key)
            "Aacute": cp = 16'h00C1; "aacute": cp = 16'h00E1; "Acirc": cp = 16'h00C2;
            "acirc": cp = 16'h00E2; "acute": cp = 16'h00B4; "AElig": cp = 16'h00C6;
            "aelig": cp = 16'h00E6; "Agrave": cp = 16'h00C0; "agrave": cp = 16'h00E0;
            "alefsym": cp = 16'h2135; "Alpha": cp = 16'h0391; "alpha": cp = 16'h03B1;
            "amp": cp = 16'h0026; "and": cp = 16'h2227; "ang": cp = 16'h2220;
            "apos": cp = 16'h0027; "Aring": cp = 16'h00C5; "aring": cp = 16'h00E5;
            "asymp": cp = 16'h2248; "Atilde": cp = 16'h00C3; "atilde": cp = 16'h00E3;
            "Auml": cp = 16'h00C4; "auml": cp = 16'h00E4; "bdquo": cp = 16'h201E;
            "Beta": cp = 16'h0392; "beta": cp = 16'h03B2; "brvbar": cp = 16'h00A6;
            "bull": cp = 16'h2022; "cap": cp = 16'h2229; "Ccedil": cp = 16'h00C7;
            "ccedil": cp = 16'h00E7; "cedil": cp = 16'h00B8; "cent": cp = 16'h00A2;
            "Chi": cp = 16'h03A7; "chi": cp = 16'h03C7; "circ": cp = 16'h02C6;
            "clubs": cp = 16'h2663; "cong": cp = 16'h2245; "copy": cp = 16'h00A9;
            "crarr": cp = 16'h21B5; "cup": cp = 16'h222A; "curren": cp = 16'h00A4;
            "dagger": cp = 16'h2020; "Dagger": cp = 16'h2021; "darr": cp = 16'h2193;
            "dArr": cp = 16'h21D3; "deg": cp = 16'h00B0; "Delta": cp = 16'h0394;
            "delta": cp = 16'h03B4; "diams": cp = 16'h2666; "divide": cp = 16'h00F7;
            "Eacute": cp = 16'h00C9; "eacute": cp = 16'h00E9; "Ecirc": cp = 16'h00CA;
            "ecirc": cp = 16'h00EA; "Egrave": cp = 16'h00C8; "egrave": cp = 16'h00E8;
            "empty": cp = 16'h2205; "emsp": cp = 16'h2003; "ensp": cp = 16'h2002;
            "Epsilon": cp = 16'h0395; "epsilon": cp = 16'h03B5; "equiv": cp = 16'h2261;
            "Eta": cp = 16'h0397; "eta": cp = 16'h03B7; "ETH": cp = 16'h00D0;
            "eth": cp = 16'h00F0; "Euml": cp = 16'h00CB; "euml": cp = 16'h00EB;
            "euro": cp = 16'h20AC; "exist": cp = 16'h2203; "fnof": cp = 16'h0192;
            "forall": cp = 16'h2200; "frac12": cp = 16'h00BD; "frac14": cp = 16'h00BC;
            "frac34": cp = 16'h00BE; "frasl": cp = 16'h2044; "Gamma": cp = 16'h0393;
            "gamma": cp = 16'h03B3; "ge": cp = 16'h2265; "harr": cp = 16'h2194;
            "hArr": cp = 16'h21D4; "hearts": cp = 16'h2665; "hellip": cp = 16'h2026;
            "Iacute": cp = 16'h00CD; "iacute": cp = 16'h00ED; "Icirc": cp = 16'h00CE;
            "icirc": cp = 16'h00EE; "iexcl": cp = 16'h00A1; "Igrave": cp = 16'h00CC;
            "igrave": cp = 16'h00EC; "image": cp = 16'h2111; "infin": cp = 16'h221E;
            "int": cp = 16'h222B; "Iota": cp = 16'h0399; "iota": cp = 16'h03B9;
            "iquest": cp = 16'h00BF; "isin": cp = 16'h2208; "Iuml": cp = 16'h00CF;
            "iuml": cp = 16'h00EF; "Kappa": cp = 16'h039A; "kappa": cp = 16'h03BA;
            "Lambda": cp = 16'h039B; "lambda": cp = 16'h03BB; "lang": cp = 16'h2329;
            "laquo": cp = 16'h00AB; "larr": cp = 16'h2190; "lArr": cp = 16'h21D0;
            "lceil": cp = 16'h2308; "ldquo": cp = 16'h201C; "le": cp = 16'h2264;
            "lfloor": cp = 16'h230A; "lowast": cp = 16'h2217; "loz": cp = 16'h25CA;
            "lrm": cp = 16'h200E; "lsaquo": cp = 16'h2039; "lsquo": cp = 16'h2018;
            "macr": cp = 16'h00AF; "mdash": cp = 16'h2014; "micro": cp = 16'h00B5;
            "middot": cp = 16'h00B7; "minus": cp = 16'h2212; "Mu": cp = 16'h039C;
            "mu": cp = 16'h03BC; "nabla": cp = 16'h2207; "nbsp": cp = 16'h00A0;
            "ndash": cp = 16'h2013; "ne": cp = 16'h2260; "ni": cp = 16'h220B;
            "not": cp = 16'h00AC; "notin": cp = 16'h2209; "nsub": cp = 16'h2284;
            "Ntilde": cp = 16'h00D1; "ntilde": cp = 16'h00F1; "Nu": cp = 16'h039D;
            "nu": cp = 16'h03BD; "Oacute": cp = 16'h00D3; "oacute": cp = 16'h00F3;
            "Ocirc": cp = 16'h00D4; "ocirc": cp = 16'h00F4; "OElig": cp = 16'h0152;
            "oelig": cp = 16'h0153; "Ograve": cp = 16'h00D2; "ograve": cp = 16'h00F2;
            "oline": cp = 16'h203E; "Omega": cp = 16'h03A9; "omega": cp = 16'h03C9;
            "Omicron": cp = 16'h039F; "omicron": cp = 16'h03BF; "oplus": cp = 16'h2295;
            "or": cp = 16'h2228; "ordf": cp = 16'h00AA; "ordm": cp = 16'h00BA;
            "Oslash": cp = 16'h00D8; "oslash": cp = 16'h00F8; "Otilde": cp = 16'h00D5;
            "otilde": cp = 16'h00F5; "otimes": cp = 16'h2297; "Ouml": cp = 16'h00D6;
            "ouml": cp = 16'h00F6; "para": cp = 16'h00B6; "part": cp = 16'h2202;
            "permil": cp = 16'h2030; "perp": cp = 16'h22A5; "Phi": cp = 16'h03A6;
            "phi": cp = 16'h03C6; "Pi": cp = 16'h03A0; "pi": cp = 16'h03C0;
            "piv": cp = 16'h03D6; "plusmn": cp = 16'h00B1; "pound": cp = 16'h00A3;
            "prime": cp = 16'h2032; "Prime": cp = 16'h2033; "prod": cp = 16'h220F;
            "prop": cp = 16'h221D; "Psi": cp = 16'h03A8; "psi": cp = 16'h03C8;
            "quot": cp = 16'h0022; "radic": cp = 16'h221A; "rang": cp = 16'h232A;
            "raquo": cp = 16'h00BB; "rarr": cp = 16'h2192; "rArr": cp = 16'h21D2;
            "rceil": cp = 16'h2309; "rdquo": cp = 16'h201D; "real": cp = 16'h211C;
            "reg": cp = 16'h00AE; "rfloor": cp = 16'h230B; "Rho": cp = 16'h03A1;
            "rho": cp = 16'h03C1; "rlm": cp = 16'h200F; "rsaquo": cp = 16'h203A;
            "rsquo": cp = 16'h2019; "sbquo": cp = 16'h201A; "Scaron": cp = 16'h0160;
            "scaron": cp = 16'h0161; "sdot": cp = 16'h22C5; "sect": cp = 16'h00A7;
            "shy": cp = 16'h00AD; "Sigma": cp = 16'h03A3; "sigma": cp = 16'h03C3;
            "sigmaf": cp = 16'h03C2; "sim": cp = 16'h223C; "spades": cp = 16'h2660;
            "sub": cp = 16'h2282; "sube": cp = 16'h2286; "sum": cp = 16'h2211;
            "sup": cp = 16'h2283; "sup1": cp = 16'h00B9; "sup2": cp = 16'h00B2;
            "sup3": cp = 16'h00B3; "supe": cp = 16'h2287; "szlig": cp = 16'h00DF;
            "Tau": cp = 16'h03A4; "tau": cp = 16'h03C4; "there4": cp = 16'h2234;
            "Theta": cp = 16'h0398; "theta": cp = 16'h03B8; "thetasym": cp = 16'h03D1;
            "thinsp": cp = 16'h2009; "THORN": cp = 16'h00DE; "thorn": cp = 16'h00FE;
            "tilde": cp = 16'h02DC; "times": cp = 16'h00D7; "trade": cp = 16'h2122;
            "Uacute": cp = 16'h00DA; "uacute": cp = 16'h00FA; "uarr": cp = 16'h2191;
            "uArr": cp = 16'h21D1; "Ucirc": cp = 16'h00DB; "ucirc": cp = 16'h00FB;
            "Ugrave": cp = 16'h00D9; "ugrave": cp = 16'h00F9; "uml": cp = 16'h00A8;
            "upsih": cp = 16'h03D2; "Upsilon": cp = 16'h03A5; "upsilon": cp = 16'h03C5;
            "Uuml": cp = 16'h00DC; "uuml": cp = 16'h00FC; "weierp": cp = 16'h2118;
            "Xi": cp = 16'h039E; "xi": cp = 16'h03BE; "Yacute": cp = 16'h00DD;
            "yacute": cp = 16'h00FD; "yen": cp = 16'h00A5; "yuml": cp = 16'h00FF;
            "Yuml": cp = 16'h0178; "Zeta": cp = 16'h0396; "zeta": cp = 16'h03B6;
            "zwj": cp = 16'h200D; "zwnj": cp = 16'h200C;
            default: hit = 1'b0;
        endcase
        return {hit, cp};
    endfunction

endpackage

// ===== hdl/hetu8_ctrl.sv =====
`timescale 1ns / 1ps
module hetu8_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  hetu8_pkg::hetu8_stat_t st,
    output hetu8_pkg::hetu8_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_FLUSH = 3'b010,
        ST_TAIL  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.accept      = s_tvalid && (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE: begin
                if (cmd.accept) begin
                    if (st.job_flush) begin
                        state_next = ST_FLUSH;
                    end else if (st.job_tail) begin
                        if (st.job_single && st.out_free) begin
                            cmd.emit_direct = 1'b1;
                        end else begin
                            state_next = ST_TAIL;
                        end
                    end
                end
            end
            ST_FLUSH: begin
                if (st.out_free) begin
                    cmd.emit_flush = 1'b1;
                    if (st.flush_last) begin
                        state_next = st.tail_pend ? ST_TAIL : ST_IDLE;
                    end
                end
            end
            ST_TAIL: begin
                if (st.out_free) begin
                    cmd.emit_tail = 1'b1;
                    if (st.tail_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_emit_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_flush || cmd.emit_tail || cmd.emit_direct) |-> st.out_free)
        else $error("emit without output room");
    a_one_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones({cmd.emit_flush, cmd.emit_tail, cmd.emit_direct}) <= 1)
        else $error("two emit commands at once");
    a_flush_to_next: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_flush && st.flush_last && !st.tail_pend) |=> s_tready)
        else $error("flush end did not return to idle");

endmodule

// ===== hdl/hetu8_dpath.sv =====
`timescale 1ns / 1ps
module hetu8_dpath #(
    parameter int MAX_NAME = hetu8_pkg::MAX_NAME_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [7:0]             s_tdata,
    input  logic                   s_tlast,
    input  hetu8_pkg::hetu8_cmd_t  cmd,
    output hetu8_pkg::hetu8_stat_t st,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata,
    output logic                   m_tlast,
    output logic                   m_tuser
);

    localparam int LW = $clog2(MAX_NAME + 1);
    localparam int IW = $clog2(MAX_NAME);

    logic          collecting_reg, collecting_next;
    logic [LW-1:0] len_reg, len_next;
    logic [63:0]   key_reg, key_next;
    logic [7:0]    name_reg [MAX_NAME];
    logic          wr_name;

    logic          flush_reg, flush_next;
    logic [LW-1:0] flen_reg, flen_next;
    logic [1:0]    tcnt_reg, tcnt_next;
    logic [7:0]    tail_reg [3];
    logic [7:0]    tail_next [3];
    logic          end_reg;
    logic [LW-1:0] pos_reg;
    logic [1:0]    tidx_reg;

    logic          out_valid_reg;
    logic [7:0]    out_byte_reg;
    logic          out_run_reg, out_end_reg;

    logic [16:0]   lk;
    logic          hit;
    logic [15:0]   cp;
    logic [1:0]    ucnt;
    logic [7:0]    u0, u1, u2;
    logic [7:0]    fl_byte;
    logic          fl_last, tl_last;

    // only names of at most eight chars can be in the table
    assign lk  = hetu8_pkg::ent_lookup(key_reg);
    assign hit = lk[16] && (len_reg <= LW'(hetu8_pkg::KEY_CHARS));
    assign cp  = lk[15:0];

    always_comb begin
        if (cp < 16'h0080) begin
            ucnt = 2'd1;
            u0 = cp[7:0]; u1 = 8'h00; u2 = 8'h00;
        end else if (cp < 16'h0800) begin
            ucnt = 2'd2;
            u0 = {3'b110, cp[10:6]}; u1 = {2'b10, cp[5:0]}; u2 = 8'h00;
        end else begin
            ucnt = 2'd3;
            u0 = {4'b1110, cp[15:12]}; u1 = {2'b10, cp[11:6]}; u2 = {2'b10, cp[5:0]};
        end
    end

    // job for the byte on the input
    always_comb begin
        collecting_next = collecting_reg;
        len_next        = len_reg;
        key_next        = key_reg;
        wr_name         = 1'b0;
        flush_next      = 1'b0;
        flen_next       = len_reg;
        tcnt_next       = 2'd0;
        tail_next[0]    = s_tdata;
        tail_next[1]    = 8'h00;
        tail_next[2]    = 8'h00;
        if (!collecting_reg) begin
            if (s_tdata == hetu8_pkg::CH_AMP) begin
                collecting_next = !s_tlast;
                len_next        = '0;
                key_next        = '0;
                tcnt_next       = s_tlast ? 2'd1 : 2'd0;
            end else begin
                tcnt_next = 2'd1;
            end
        end else if (hetu8_pkg::is_alnum(s_tdata)) begin
            if (len_reg < LW'(MAX_NAME)) begin
                wr_name  = 1'b1;
                len_next = len_reg + 1'b1;
                key_next = {key_reg[55:0], s_tdata};
                if (s_tlast) begin
                    flush_next      = 1'b1;
                    flen_next       = len_reg + 1'b1;
                    collecting_next = 1'b0;
                    len_next        = '0;
                end
            end else begin
                flush_next      = 1'b1;
                tcnt_next       = 2'd1;
                collecting_next = 1'b0;
                len_next        = '0;
            end
        end else if (s_tdata == hetu8_pkg::CH_SEMI && hit) begin
            tcnt_next       = ucnt;
            tail_next[0]    = u0;
            tail_next[1]    = u1;
            tail_next[2]    = u2;
            collecting_next = 1'b0;
            len_next        = '0;
        end else if (s_tdata == hetu8_pkg::CH_AMP) begin
            // old name goes out raw, a fresh one starts unless the stream ends here
            flush_next      = 1'b1;
            collecting_next = !s_tlast;
            len_next        = '0;
            key_next        = '0;
            tcnt_next       = s_tlast ? 2'd1 : 2'd0;
        end else begin
            flush_next      = 1'b1;
            tcnt_next       = 2'd1;
            collecting_next = 1'b0;
            len_next        = '0;
        end
    end

    assign fl_byte = (pos_reg == '0) ? hetu8_pkg::CH_AMP
                                     : name_reg[IW'(pos_reg - 1'b1)];
    assign fl_last = (pos_reg == flen_reg);
    assign tl_last = (tidx_reg == tcnt_reg - 2'd1);

    assign st.job_flush  = flush_next;
    assign st.job_tail   = (tcnt_next != 2'd0);
    assign st.tail_pend  = (tcnt_reg != 2'd0);
    assign st.job_single = (tcnt_next == 2'd1);
    assign st.flush_last = fl_last;
    assign st.tail_last  = tl_last;
    assign st.out_free   = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            collecting_reg <= 1'b0;
            len_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cmd.accept) begin
                collecting_reg <= collecting_next;
                len_reg        <= len_next;
            end
            if (cmd.emit_direct || cmd.emit_flush || cmd.emit_tail) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            key_reg      <= key_next;
            flush_reg    <= flush_next;
            flen_reg     <= flen_next;
            tcnt_reg     <= tcnt_next;
            tail_reg[0]  <= tail_next[0];
            tail_reg[1]  <= tail_next[1];
            tail_reg[2]  <= tail_next[2];
            end_reg      <= s_tlast;
            pos_reg      <= '0;
            tidx_reg     <= 2'd0;
            if (wr_name) begin
                name_reg[IW'(len_reg)] <= s_tdata;
            end
        end
        if (cmd.emit_flush) begin
            pos_reg <= pos_reg + 1'b1;
        end
        if (cmd.emit_tail) begin
            tidx_reg <= tidx_reg + 2'd1;
        end
        if (cmd.emit_direct) begin
            out_byte_reg <= tail_next[0];
            out_run_reg  <= 1'b1;
            out_end_reg  <= s_tlast;
        end else if (cmd.emit_flush) begin
            out_byte_reg <= fl_byte;
            out_run_reg  <= fl_last && (tcnt_reg == 2'd0);
            out_end_reg  <= fl_last && (tcnt_reg == 2'd0) && end_reg;
        end else if (cmd.emit_tail) begin
            out_byte_reg <= tail_reg[tidx_reg];
            out_run_reg  <= tl_last;
            out_end_reg  <= tl_last && end_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_end_reg;
    assign m_tuser  = out_run_reg;

    a_idle_len: assert property (@(posedge aclk) disable iff (!aresetn)
        !collecting_reg |-> (len_reg == '0))
        else $error("name length held outside collection");
    a_len_max: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LW'(MAX_NAME))
        else $error("name length beyond limit");
    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && s_tlast) |=> !collecting_reg)
        else $error("collection survived end of stream");
    a_flush_job: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_flush |-> flush_reg)
        else $error("flush emitted without flush job");

endmodule

// ===== hdl/html_entity_to_utf8_decoder_core.sv =====
`timescale 1ns / 1ps
// latency: a single-byte result with the output register free is on m_ the cycle after the
// input transfer; raw flush bytes, multi-byte encodings or a busy output go via ST_FLUSH/ST_TAIL
// throughput: an input with one plain result is taken while its result goes to the output;
// else s_tready is low while the emit sequencer sends one result byte per cycle when m_ has room
// inputs that leave the name held and yield no result leave s_tready high for the next input
// reset: aresetn synchronous active low, back to pass-through mode with no output pending
module html_entity_to_utf8_decoder_core #(
    parameter int MAX_NAME = hetu8_pkg::MAX_NAME_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // in_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,   // out_stream_end
    output logic       m_tuser    // [0] out_last_of_run
);

    // command and status between the sequencer and the datapath
    hetu8_pkg::hetu8_cmd_t  cmd;
    hetu8_pkg::hetu8_stat_t st;

    // sequencer: takes a transfer, then walks raw flush bytes and tail bytes
    hetu8_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    // datapath: name buffer, table match, utf-8 encode, output register
    hetu8_dpath #(
        .MAX_NAME (MAX_NAME)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .cmd      (cmd),
        .st       (st),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
